// ===== sv/assert_macros.svh =====
// Assertion macros included by the emitter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk, off during rst
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising edge of clk, off during rst
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/b2d_pkg.sv =====
// Shared types, constants and helpers for the binary to decimal digit emitter
package b2d_pkg;

  localparam int CHAR_W         = 6;
  localparam int DIGIT_W        = 4;
  localparam int BITS_PER_STAGE = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // Shift-add-3 correction of one BCD digit ahead of a left shift
  function automatic digit_t dabble_adj(input digit_t d);
    digit_t r;
    r = d;
    if (d >= 4'd5) begin
      r = d + 4'd3;
    end
    return r;
  endfunction

endpackage

// ===== sv/b2d_value_if.sv =====
// Input channel: one binary value per transaction
interface b2d_value_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/b2d_digit_if.sv =====
// Output channel: one ASCII digit per transaction, with end-of-run flag
interface b2d_digit_if;
  import b2d_pkg::*;

  logic  valid;
  logic  ready;
  char_t digit_char;
  logic  last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ===== sv/binary_to_decimal_digit_emitter_unit.sv =====
// Top level: pipelined double-dabble converter with a digit serializer
//
//  channel  dir  transaction payload
//  -------  ---  ---------------------------------------
//  number   in   value (VALUE_WIDTH bits, unsigned)
//  text     out  digit_char (6 bits ASCII), last (1 bit)
//
// Conversion runs in ceil(VALUE_WIDTH/4) register stages, 4 bits per stage
// (8 stages at 32 bits); a value can enter every cycle the last stage frees up.
// The serializer emits one digit per cycle unless text stalls; a value holds
// the output for its digit count, 1 to MAX_DIGITS digits; that sets throughput.
// rst is synchronous and clears all valid bits; no data store needs clearing.
// A stall on text holds the output register and serializer; the pipeline keeps
// advancing until its last stage waits on the serializer, then holds as a whole.
module binary_to_decimal_digit_emitter_unit #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 10
) (
  input  logic               clk,
  input  logic               rst,
  b2d_value_if.sink          number,
  b2d_digit_if.source        text
);
  import b2d_pkg::*;

  `include "assert_macros.svh"

  localparam int NUM_STAGES = (VALUE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int PAD_W      = NUM_STAGES * BITS_PER_STAGE;
  localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int LAST       = NUM_STAGES - 1;

  // conversion pipeline
  logic             st_valid [NUM_STAGES];
  logic [BCD_W-1:0] st_bcd   [NUM_STAGES];
  logic [PAD_W-1:0] st_bin   [NUM_STAGES];

  // serializer and output register
  logic             ser_busy;
  logic [BCD_W-1:0] ser_bcd;
  logic [IDX_W-1:0] ser_pos;
  logic             txt_valid;
  char_t            txt_char;
  logic             txt_last;

  logic             txt_free;
  logic             emit;
  logic             ser_done;
  logic             ser_take;
  logic             load;
  logic             adv;
  logic [IDX_W-1:0] top;
  digit_t           cur_digit;

  assign txt_free = !txt_valid || text.ready;
  assign emit     = ser_busy && txt_free;
  assign ser_done = emit && (ser_pos == '0);
  assign ser_take = !ser_busy || ser_done;
  assign load     = ser_take && st_valid[LAST];
  assign adv      = !st_valid[LAST] || ser_take;

  assign number.ready = adv;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    logic [BCD_W-1:0] bcd_in;
    logic [BCD_W-1:0] bcd_out;
    logic [PAD_W-1:0] bin_in;
    logic [PAD_W-1:0] bin_out;
    logic             vld_in;

    if (s == 0) begin : g_head
      assign bcd_in = '0;
      assign bin_in = PAD_W'(number.value[VALUE_WIDTH-1:0]);
      assign vld_in = number.valid;
    end else begin : g_body
      assign bcd_in = st_bcd[s-1];
      assign bin_in = st_bin[s-1];
      assign vld_in = st_valid[s-1];
    end

    always_comb begin
      bcd_out = bcd_in;
      bin_out = bin_in;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
          bcd_out[d*DIGIT_W +: DIGIT_W] = dabble_adj(bcd_out[d*DIGIT_W +: DIGIT_W]);
        end
        // carry out of the top digit is dropped: only low MAX_DIGITS digits kept
        bcd_out = {bcd_out[BCD_W-2:0], bin_out[PAD_W-1]};
        bin_out = {bin_out[PAD_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s] <= 1'b0;
      end else if (adv) begin
        st_valid[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_bcd[s] <= bcd_out;
        st_bin[s] <= bin_out;
      end
    end
  end

  // highest nonzero digit; digit 0 when the whole value is zero
  always_comb begin
    top = '0;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (st_bcd[LAST][d*DIGIT_W +: DIGIT_W] != '0) begin
        top = IDX_W'(d);
      end
    end
  end

  assign cur_digit = ser_bcd[ser_pos*DIGIT_W +: DIGIT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_busy <= 1'b0;
    end else if (load) begin
      ser_busy <= 1'b1;
    end else if (ser_done) begin
      ser_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser_bcd <= st_bcd[LAST];
      ser_pos <= top;
    end else if (emit) begin
      ser_pos <= ser_pos - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      txt_valid <= 1'b0;
    end else if (emit) begin
      txt_valid <= 1'b1;
    end else if (text.ready) begin
      txt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      txt_char <= ASCII_ZERO + CHAR_W'(cur_digit);
      txt_last <= (ser_pos == '0);
    end
  end

  assign text.valid      = txt_valid;
  assign text.digit_char = txt_char;
  assign text.last       = txt_last;

  `CHK_NEXT(a_last_flag, emit, txt_valid && (txt_last == $past(ser_pos == '0)),
    "last flag does not match serializer position")
  `CHK_NEXT(a_no_leading_zero, load,
    ser_busy && ((ser_pos == '0) || (ser_bcd[ser_pos*DIGIT_W +: DIGIT_W] != '0)),
    "run starts on a leading zero")
  `CHK_NEXT(a_pipe_hold, st_valid[LAST] && !ser_take,
    st_valid[LAST] && $stable(st_bcd[LAST]), "stalled pipeline result lost or changed")
  `CHK_NOW(a_pos_range, ser_busy, ser_pos < MAX_DIGITS, "serializer position out of range")

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the binary to decimal digit emitter: table-driven and random values
`timescale 1ns / 100ps

module tb_top;
  import b2d_pkg::*;

  localparam int VALUE_WIDTH  = 32;
  localparam int MAX_DIGITS   = 10;
  localparam int N_DIRECTED   = 21;
  localparam int N_RANDOM     = 239;
  localparam int IDLE_PCT     = 27;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    string                  text;   // expected digits typed in; empty means use the predictor
  } number_item_t;

  typedef struct packed {
    char_t digit_char;
    logic  last;
  } digit_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  b2d_value_if #(.VALUE_WIDTH(VALUE_WIDTH)) number_if ();
  b2d_digit_if                              text_if ();

  binary_to_decimal_digit_emitter_unit #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .number(number_if),
    .text  (text_if)
  );

  number_item_t  directed_rows [N_DIRECTED];
  number_item_t  number_q [$];
  number_item_t  item_on_bus;
  digit_result_t pending_digits [$];

  int values_sent     = 0;
  int values_accepted = 0;
  int digits_checked  = 0;
  int mismatches      = 0;
  int quiet_cycles    = 0;
  int run_len         = 0;
  int runs_by_len [MAX_DIGITS+1];

  // no idling on either side while this window of values goes through
  wire calm = (values_accepted >= 130) && (values_accepted < 190);

  // Expected run for one value, least significant digits kept, leading zeros dropped
  function automatic void push_decimal_digits(input logic [VALUE_WIDTH-1:0] v);
    digit_t                 dec [MAX_DIGITS];
    logic [VALUE_WIDTH-1:0] rest;
    int                     top;
    digit_result_t          r;
    rest = v;
    top  = 0;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      dec[k] = digit_t'(rest % 10);
      rest   = rest / 10;
    end
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (dec[k] != '0) begin
        top = k;
      end
    end
    for (int k = top; k >= 0; k--) begin
      r.digit_char = ASCII_ZERO + char_t'(dec[k]);
      r.last       = (k == 0);
      pending_digits.push_back(r);
    end
  endfunction

  function automatic void push_typed_digits(input string s);
    digit_result_t r;
    for (int i = 0; i < s.len(); i++) begin
      r.digit_char = char_t'(s[i]);
      r.last       = (i == s.len() - 1);
      pending_digits.push_back(r);
    end
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] random_value();
    longint lo;
    longint hi;
    longint p;
    int     n;
    int     pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      return $urandom();
    end else if (pick < 45) begin
      // just around a power of ten
      p = 1;
      n = $urandom_range(9);
      for (int k = 0; k < n; k++) begin
        p = p * 10;
      end
      p = p - 1 + $urandom_range(2);
      return p[VALUE_WIDTH-1:0];
    end
    // spread over digit counts so short runs show up as often as long ones
    n  = $urandom_range(MAX_DIGITS, 1);
    lo = 1;
    for (int k = 1; k < n; k++) begin
      lo = lo * 10;
    end
    hi = (n == MAX_DIGITS) ? 64'd4294967295 : lo * 10 - 1;
    if (n == 1) begin
      lo = 0;
    end
    return VALUE_WIDTH'($urandom_range(32'(hi), 32'(lo)));
  endfunction

  initial begin
    number_if.valid = 1'b0;
    number_if.value = '0;
    text_if.ready   = 1'b0;
  end

  // number source
  always @(posedge clk) begin
    if (rst) begin
      number_if.valid <= 1'b0;
    end else if (!number_if.valid || number_if.ready) begin
      if (number_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        item_on_bus     <= number_q[0];
        number_if.value <= number_q[0].value;
        number_if.valid <= 1'b1;
        void'(number_q.pop_front());
      end else begin
        number_if.valid <= 1'b0;
      end
    end
  end

  // text sink
  always @(posedge clk) begin
    if (rst) begin
      text_if.ready <= 1'b0;
    end else begin
      text_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // expectations are queued when the value transaction is taken
  always @(posedge clk) begin
    if (!rst && number_if.valid && number_if.ready) begin
      if (item_on_bus.text != "") begin
        push_typed_digits(item_on_bus.text);
      end else begin
        push_decimal_digits(number_if.value);
      end
      values_accepted <= values_accepted + 1;
    end
  end

  always @(posedge clk) begin
    digit_result_t want;
    if (!rst && text_if.valid && text_if.ready) begin
      digits_checked <= digits_checked + 1;
      if (pending_digits.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTS) begin
          $display("tb_top: unexpected digit char=%0d last=%0b",
                   text_if.digit_char, text_if.last);
        end
      end else begin
        want = pending_digits.pop_front();
        if (text_if.digit_char !== want.digit_char || text_if.last !== want.last) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS) begin
            $display("tb_top: digit mismatch: expected char=%0d last=%0b, got char=%0d last=%0b",
                     want.digit_char, want.last, text_if.digit_char, text_if.last);
          end
        end
      end
      if (text_if.last === 1'b1) begin
        if (run_len + 1 <= MAX_DIGITS) begin
          runs_by_len[run_len+1] <= runs_by_len[run_len+1] + 1;
        end
        run_len <= 0;
      end else begin
        run_len <= run_len + 1;
      end
    end
  end

  // cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (number_if.valid && number_if.ready) || (text_if.valid && text_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
    end
    $display("tb_top: no transaction for %0d cycles", QUIET_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int           seen_lengths;
    number_item_t row;
    for (int k = 0; k <= MAX_DIGITS; k++) begin
      runs_by_len[k] = 0;
    end
    directed_rows = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{32'd99,         ""},
      '{32'd100,        ""},
      '{32'd4294967295, "4294967295"},
      '{32'd4294967294, ""},
      '{32'd1000000000, "1000000000"},
      '{32'd999999999,  "999999999"},
      '{32'd0,          "0"},
      '{32'h80000000,   ""},
      '{32'hAAAAAAAA,   ""},
      '{32'h55555555,   ""},
      '{32'd123456789,  "123456789"},
      '{32'd1234567890, "1234567890"},
      '{32'd4000000000, ""},
      '{32'h0000FFFF,   ""},
      '{32'h0F0F0F0F,   ""},
      '{32'hF0F0F0F0,   ""},
      '{32'd3000000001, ""}
    };
    for (int i = 0; i < N_DIRECTED; i++) begin
      number_q.push_back(directed_rows[i]);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      row.value = random_value();
      row.text  = "";
      number_q.push_back(row);
    end
    values_sent = number_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (values_accepted < values_sent || pending_digits.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    seen_lengths = 0;
    for (int k = 1; k <= MAX_DIGITS; k++) begin
      if (runs_by_len[k] != 0) begin
        seen_lengths++;
      end
    end
    $display("tb_top: %0d values converted, %0d digits checked, %0d mismatches",
             values_accepted, digits_checked, mismatches);
    $display("tb_top: %0d of %0d run lengths seen, zero and full-scale values included",
             seen_lengths, MAX_DIGITS);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
